@@ rtl/upat_pkg.sv @@
`default_nettype none
package upat_pkg;

  localparam int MAX_PACKETS = 256;
  localparam int IDX_W       = $clog2(MAX_PACKETS);
  localparam int CNT_W       = $clog2(MAX_PACKETS + 1);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [2:0] ST_REJECTED  = 3'd0;
  localparam logic [2:0] ST_DEFERRED  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_ACCEPTED  = 3'd3;
  localparam logic [2:0] ST_COMPLETE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_SESSION = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 4'd1;

  typedef struct packed {
    logic [7:0]  session;
    logic [31:0] update_time;
    logic [15:0] packet_index;
    logic [15:0] packet_total;
    logic        well_formed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  missing_count;
    logic [31:0] pending_time;
    logic [31:0] current_time;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/update_packet_arrival_tracker_core.sv @@
// channel   dir  handshake           payload
// in_       in   in_valid/in_stall   in_data   (in_item_t)
// out_      out  out_valid/out_stall out_data  (out_item_t)
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; an accepted item passes through the input
// register, then the bitmap and count update into the result register
// rst_n is synchronous: clears the bitmap, counts and stamps (start time 0, session 0)
// writing the start time clears the bitmap and counts and loads both stamps
// out_stall holds the result register; in_stall rises only when both registers are full
`default_nettype none
module update_packet_arrival_tracker_core
  import upat_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic      adv;
  logic      fire;
  logic      s1_valid;
  in_item_t  s1_item;
  out_item_t result;

  assign cfg_ready = 1'b1;

  upat_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  upat_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  upat_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .result    (result),
    .adv       (adv),
    .fire      (fire),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_complete_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_COMPLETE)) |->
      ((out_data.missing_count == 9'd0) &&
       (out_data.current_time == out_data.pending_time)))
    else $error("completed update still missing packets or stamps differ");

  a_accept_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_ACCEPTED)) |-> (out_data.missing_count != 9'd0))
    else $error("accepted packet leaves nothing missing but not complete");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed item produced no result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free register");

endmodule
`default_nettype wire

@@ rtl/upat_in_stage.sv @@
`default_nettype none
module upat_in_stage
  import upat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     adv,
  output logic          s1_valid,
  output in_item_t      s1_item
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     accept;

  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule
`default_nettype wire

@@ rtl/upat_track.sv @@
`default_nettype none
module upat_track
  import upat_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire in_item_t              item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t                  result
);

  logic [7:0]             own_r;
  logic [MAX_PACKETS-1:0] map_r;
  logic [MAX_PACKETS-1:0] map_nxt;
  logic [CNT_W-1:0]       exp_r, exp_nxt;
  logic [CNT_W-1:0]       rcv_r, rcv_nxt;
  logic [31:0]            pend_r, pend_nxt;
  logic [31:0]            cur_r, cur_nxt;
  logic [2:0]             status;
  logic                   clr;
  logic                   mark;
  logic                   deferred;
  logic                   rej_hdr;
  logic [31:0]            age;
  logic [IDX_W-1:0]       idx;
  logic [CNT_W-1:0]       tot;

  // serial compare: older when the modular difference has its top bit set
  assign age = item.update_time - pend_r;
  assign idx = item.packet_index[IDX_W-1:0];
  assign tot = item.packet_total[CNT_W-1:0];

  assign rej_hdr = (item.session != own_r) || age[31] || !item.well_formed ||
                   (item.packet_total == 16'd0) ||
                   (item.packet_total > 16'(MAX_PACKETS));

  always_comb begin
    status   = ST_REJECTED;
    exp_nxt  = exp_r;
    rcv_nxt  = rcv_r;
    pend_nxt = pend_r;
    cur_nxt  = cur_r;
    clr      = 1'b0;
    mark     = 1'b0;
    deferred = 1'b0;
    if (!rej_hdr) begin
      // first packet after reset or after a start time write, with nothing expected
      if ((pend_r == cur_r) && (exp_r == '0)) begin
        clr     = 1'b1;
        exp_nxt = tot;
        rcv_nxt = '0;
      end
      if (pend_r != item.update_time) begin
        if (exp_nxt != rcv_nxt) begin
          deferred = 1'b1;
          status   = ST_DEFERRED;
        end else begin
          clr      = 1'b1;
          exp_nxt  = tot;
          rcv_nxt  = '0;
          pend_nxt = item.update_time;
        end
      end
      if (!deferred) begin
        if (item.packet_total != 16'(exp_nxt)) begin
          status = ST_REJECTED;
        end else if (item.packet_index >= 16'(exp_nxt)) begin
          status = ST_REJECTED;
        end else if (!clr && map_r[idx]) begin
          status = ST_DUPLICATE;
        end else begin
          mark    = 1'b1;
          rcv_nxt = rcv_nxt + 1'b1;
          if (rcv_nxt == exp_nxt) begin
            cur_nxt = item.update_time;
            status  = ST_COMPLETE;
          end else begin
            status  = ST_ACCEPTED;
          end
        end
      end
    end
  end

  always_comb begin
    map_nxt = clr ? '0 : map_r;
    if (mark) begin
      map_nxt[idx] = 1'b1;
    end
  end

  assign result.status        = status;
  assign result.missing_count = 9'(exp_nxt - rcv_nxt);
  assign result.pending_time  = pend_nxt;
  assign result.current_time  = cur_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r  <= '0;
      map_r  <= '0;
      exp_r  <= '0;
      rcv_r  <= '0;
      pend_r <= '0;
      cur_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_SESSION: begin
          own_r <= cfg_data[7:0];
        end
        CFG_START_TIME: begin
          map_r  <= '0;
          exp_r  <= '0;
          rcv_r  <= '0;
          pend_r <= cfg_data;
          cur_r  <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (fire) begin
      map_r  <= map_nxt;
      exp_r  <= exp_nxt;
      rcv_r  <= rcv_nxt;
      pend_r <= pend_nxt;
      cur_r  <= cur_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/upat_out_stage.sv @@
`default_nettype none
module upat_out_stage
  import upat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      s1_valid,
  input  wire out_item_t result,
  output logic           adv,
  output logic           fire,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;

  // the result register can load when empty or when its item leaves this cycle
  assign adv  = !out_valid_r || !out_stall;
  assign fire = s1_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ tb/tracker_checker.sv @@
`timescale 1ns / 1ps
module tracker_checker
  import upat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    results_owed
);

  logic [MAX_PACKETS-1:0] seen_map;
  logic [8:0]             want_cnt;
  logic [8:0]             got_cnt;
  logic [31:0]            pend_stamp;
  logic [31:0]            cur_stamp;
  logic [7:0]             my_sess;
  logic [31:0]            start_stamp;
  out_item_t              reports_q[$];
  int                     bad = 0;

  task automatic restart_tracker();
    seen_map   = '0;
    want_cnt   = '0;
    got_cnt    = '0;
    pend_stamp = start_stamp;
    cur_stamp  = start_stamp;
  endtask

  task automatic predict_header(input in_item_t h, output out_item_t r);
    logic [31:0] age;
    logic [2:0]  st;
    age = h.update_time - pend_stamp;
    st  = ST_REJECTED;
    if (h.session == my_sess && !age[31] && h.well_formed &&
        h.packet_total != 0 && h.packet_total <= MAX_PACKETS) begin
      // nothing expected yet: the first header sets the count
      if (pend_stamp == cur_stamp && want_cnt == 0) begin
        seen_map = '0;
        want_cnt = h.packet_total[8:0];
        got_cnt  = '0;
      end
      if (pend_stamp != h.update_time && want_cnt != got_cnt) begin
        st = ST_DEFERRED;
      end else begin
        if (pend_stamp != h.update_time) begin
          seen_map   = '0;
          want_cnt   = h.packet_total[8:0];
          got_cnt    = '0;
          pend_stamp = h.update_time;
        end
        if (h.packet_total != 16'(want_cnt) || h.packet_index >= 16'(want_cnt)) begin
          st = ST_REJECTED;
        end else if (seen_map[h.packet_index[7:0]]) begin
          st = ST_DUPLICATE;
        end else begin
          seen_map[h.packet_index[7:0]] = 1'b1;
          got_cnt = got_cnt + 9'd1;
          if (got_cnt == want_cnt) begin
            cur_stamp = h.update_time;
            st = ST_COMPLETE;
          end else begin
            st = ST_ACCEPTED;
          end
        end
      end
    end
    r.status        = st;
    r.missing_count = want_cnt - got_cnt;
    r.pending_time  = pend_stamp;
    r.current_time  = cur_stamp;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      my_sess     = '0;
      start_stamp = '0;
      restart_tracker();
      reports_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_q.size() == 0) begin
          $display("%0t: result with none expected, got %h", $time, out_data);
          bad++;
        end else begin
          want = reports_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data.status);
            bad++;
          end
          if (out_data.missing_count !== want.missing_count) begin
            $display("%0t: missing_count expected %0d got %0d", $time,
                     want.missing_count, out_data.missing_count);
            bad++;
          end
          if (out_data.pending_time !== want.pending_time) begin
            $display("%0t: pending_time expected %h got %h", $time,
                     want.pending_time, out_data.pending_time);
            bad++;
          end
          if (out_data.current_time !== want.current_time) begin
            $display("%0t: current_time expected %h got %h", $time,
                     want.current_time, out_data.current_time);
            bad++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OWN_SESSION) begin
          my_sess = cfg_data[7:0];
        end else if (cfg_index == CFG_START_TIME) begin
          start_stamp = cfg_data;
          restart_tracker();
        end
      end
      if (in_valid && !in_stall) begin
        predict_header(in_data, want);
        reports_q = {reports_q, want};
      end
    end
    mismatches   <= bad;
    results_owed <= reports_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import upat_pkg::*;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    mismatches;
  int                    results_owed;

  logic        steady   = 1'b0;
  logic        hold_req = 1'b0;
  logic [7:0]  own_id   = '0;
  logic [31:0] base     = '0;

  update_packet_arrival_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tracker_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off per request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < 60; n++) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(99) < 37);
    end
  end

  function automatic in_item_t raw(logic [7:0] s, logic [31:0] t, logic [15:0] i,
                                   logic [15:0] n, logic w);
    in_item_t h;
    h.session      = s;
    h.update_time  = t;
    h.packet_index = i;
    h.packet_total = n;
    h.well_formed  = w;
    return h;
  endfunction

  function automatic in_item_t header(logic [31:0] t, int i, int n);
    return raw(own_id, t, 16'(i), 16'(n), 1'b1);
  endfunction

  task automatic push_header(input in_item_t h);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= h;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [7:0] sess, input logic [31:0] start);
    write_reg(CFG_OWN_SESSION, {24'd0, sess});
    write_reg(CFG_START_TIME, start);
    cfg_valid <= 1'b0;
    own_id = sess;
    base   = start;
    @(posedge clk);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic directed_headers();
    in_item_t d[$];
    d = {d, raw(8'h00, 32'h0, 16'd0, 16'd1, 1'b1)};
    d = {d, raw(8'hFF, 32'h0, 16'd0, 16'd1, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd0, 16'd1, 1'b0)};
    d = {d, raw(8'hA5, 32'h0, 16'd0, 16'd0, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd0, 16'd257, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd0, 16'hFFFF, 1'b1)};
    d = {d, raw(8'hA5, 32'h8000_0000, 16'd0, 16'd1, 1'b1)};
    d = {d, raw(8'hA5, 32'hFFFF_FFFF, 16'd0, 16'd1, 1'b1)};
    // first header sets the count, then duplicate, wrong count, bad index
    d = {d, raw(8'hA5, 32'h0, 16'd1, 16'd3, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd1, 16'd3, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd0, 16'd4, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd3, 16'd3, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'hFFFF, 16'd3, 1'b1)};
    d = {d, raw(8'hA5, 32'h5, 16'd0, 16'd2, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd0, 16'd3, 1'b1)};
    d = {d, raw(8'hA5, 32'h0, 16'd2, 16'd3, 1'b1)};
    // new update started by a header whose index is out of range
    d = {d, raw(8'hA5, 32'h7FFF_FFFF, 16'd5, 16'd1, 1'b1)};
    d = {d, raw(8'hA5, 32'h7FFF_FFFF, 16'd0, 16'd1, 1'b1)};
    d = {d, raw(8'hA5, 32'hFFFF_FFFE, 16'd255, 16'd256, 1'b1)};
    d = {d, raw(8'hA5, 32'hFFFF_FFFE, 16'd0, 16'd256, 1'b1)};
    d = {d, raw(8'hA5, 32'hFFFF_FFFF, 16'd0, 16'd256, 1'b1)};
    d = {d, raw(8'hA5, 32'h7FFF_FFFE, 16'd0, 16'd256, 1'b1)};
    d = {d, raw(8'hA5, 32'hFFFF_FFFE, 16'd255, 16'd256, 1'b1)};
    foreach (d[k]) push_header(d[k]);
  endtask

  task automatic random_phase(input int quota);
    int          sent, n, cnt, k, j, tmp, lost;
    int          order[256];
    logic        fresh, held;
    logic [31:0] stamp;
    in_item_t    h;
    sent  = 0;
    fresh = 1'b1;
    held  = 1'b0;
    while (sent < quota) begin
      if (!held && sent >= 10) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
        // after a start time write only that time can open the first update
        if (fresh) stamp = base;
        else begin
          case ($urandom_range(9))
            0:       stamp = base;
            1:       stamp = base + $urandom_range(32'h7FFF_FFFF, 1);
            default: stamp = base + $urandom_range(1000, 1);
          endcase
        end
        fresh = 1'b0;
        for (k = 0; k < n; k++) order[k] = k;
        for (k = n - 1; k > 0; k--) begin
          j = $urandom_range(k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        cnt  = n;
        lost = -1;
        if ($urandom_range(9) == 0) begin
          cnt  = n - 1;
          lost = order[n-1];
        end
        for (k = 0; k < cnt; k++) begin
          h = header(stamp, order[k], n);
          push_header(h);
          sent++;
          if (k > 0 && $urandom_range(15) == 0) begin
            case ($urandom_range(2))
              0:       h.packet_total = 16'(n + 1);
              1:       h.packet_index = 16'(n + $urandom_range(300));
              default: ;
            endcase
            push_header(h);
            sent++;
          end
        end
        if (lost >= 0) begin
          // newer header while one is missing, then the missing one
          push_header(header(stamp + $urandom_range(50, 1), 0, 1));
          push_header(header(stamp, lost, n));
          sent += 2;
        end
        base = stamp;
      end else begin
        h.session      = $urandom_range(1) ? own_id : 8'($urandom);
        h.update_time  = $urandom;
        h.packet_index = 16'($urandom);
        h.packet_total = 16'($urandom);
        h.well_formed  = 1'($urandom);
        // keep noise from opening an update
        if (h.packet_total != 0 && h.packet_total <= MAX_PACKETS) h.well_formed = 1'b0;
        push_header(h);
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0]  sess_set[4];
    logic [31:0] start_set[4];
    int          p;
    sess_set  = '{8'h00, 8'hFF, 8'h3C, 8'($urandom)};
    start_set = '{32'hFFFF_FFFF, 32'h7FFF_FFF8, 32'h8000_0000, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(8'hA5, 32'h0);
    directed_headers();
    settle();
    for (p = 0; p < 4; p++) begin
      configure(sess_set[p], start_set[p]);
      steady = (p == 1);
      random_phase(100);
      steady = 1'b0;
      settle();
    end
    if (mismatches == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
